// ----- hw/rtl/isrch_pkg.sv -----
// ----------------------------------------------------------------------------
// isrch_pkg
// Shared types and constants for the interpolation search block.
// ----------------------------------------------------------------------------
package isrch_pkg;

  // default table depth
  localparam int ISRCH_DEPTH = 1024;

  // fixed field widths
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 10;
  localparam int POS_W   = 10;
  localparam int TSIZE_W = 11;

  // register reset value
  localparam logic [TSIZE_W-1:0] TSIZE_RESET = TSIZE_W'(1024);

  // input function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

// ----- hw/rtl/interpolation_search.sv -----
// ----------------------------------------------------------------------------
// interpolation_search
// Sorted table of signed values with interpolation search lookups.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    func, entry_index, entry_value, key
//   out      output     out_valid / out_ready  found, position
//   cfg      input      cfg_valid / cfg_ready  cfg_data (table_size)
//
// A write transaction gives no result.
// A search, for each probe, reads both window ends, checks the window, runs the
// probe divider, one quotient bit a cycle, then reads and checks the probe; it
// ends on a hit, a key outside the window, a one-entry or flat window or an
// empty window, then waits for the output register. Reset clears control
// state and sets table_size to 1024; the table is not cleared. The input is
// not ready while a search runs or its result waits for the output register.
// ----------------------------------------------------------------------------
module interpolation_search
  import isrch_pkg::*;
#(
  parameter int DEPTH = ISRCH_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [IDX_W-1:0]   entry_index,
  input  data_t              entry_value,
  input  data_t              key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [POS_W-1:0]   position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TSIZE_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDLO = 4'd1;
  localparam logic [3:0] S_RDHI = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_DIVW = 4'd4;
  localparam logic [3:0] S_PRB  = 4'd5;
  localparam logic [3:0] S_PCHK = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0]         state;
  logic [3:0]         state_next;
  logic [TSIZE_W-1:0] table_size;
  logic [AW-1:0]      lo;
  logic [AW-1:0]      hi;
  logic [AW-1:0]      probe;
  data_t              key_r;
  data_t              tl;
  logic               res_found;
  logic [AW-1:0]      res_pos;

  logic               in_acc;
  logic               tbl_we;
  logic [AW-1:0]      raddr;
  data_t              rdata;
  logic [31:0]        tsize_eff;
  logic [DATA_W:0]    num_w;
  logic [DATA_W:0]    den_w;
  logic               div_start;
  logic               div_done;
  logic [AW-1:0]      quo;
  logic [AW-1:0]      probe_w;
  logic               out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign tbl_we    = in_acc && (func == FUNC_WRITE) && (32'(entry_index) < DEPTH);
  assign out_free  = !out_valid || out_ready;
  assign probe_w   = lo + quo;

  // effective table size, capped at the depth
  assign tsize_eff = (32'(table_size) > DEPTH) ? DEPTH : 32'(table_size);

  // interpolation operands, nonnegative inside the search window
  assign num_w = {key_r[DATA_W-1], key_r} - {tl[DATA_W-1], tl};
  assign den_w = {rdata[DATA_W-1], rdata} - {tl[DATA_W-1], tl};

  assign div_start = (state == S_CHK) && (key_r >= tl) && (key_r <= rdata) &&
                     (lo != hi) && (rdata != tl);

  // table read address by step
  always_comb begin
    case (state)
      S_RDLO:  raddr = lo;
      S_RDHI:  raddr = hi;
      S_PRB:   raddr = probe_w;
      default: raddr = lo;
    endcase
  end

  isrch_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(entry_index)),
    .wdata (entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  isrch_div #(
    .AW (AW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .span  (hi - lo),
    .num   (num_w[DATA_W-1:0]),
    .den   (den_w[DATA_W-1:0]),
    .done  (div_done),
    .quo   (quo)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && func == FUNC_SEARCH) begin
          state_next = (table_size == '0) ? S_DONE : S_RDLO;
        end
      end
      S_RDLO: state_next = S_RDHI;
      S_RDHI: state_next = S_CHK;
      S_CHK:  state_next = div_start ? S_DIVW : S_DONE;
      S_DIVW: begin
        if (div_done) begin
          state_next = S_PRB;
        end
      end
      S_PRB:  state_next = S_PCHK;
      S_PCHK: begin
        if (rdata == key_r) begin
          state_next = S_DONE;
        end else if (rdata < key_r) begin
          state_next = (probe == hi) ? S_DONE : S_RDLO;
        end else begin
          state_next = (probe == lo) ? S_DONE : S_RDLO;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      table_size <= TSIZE_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        table_size <= cfg_data;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        key_r     <= key;
        lo        <= '0;
        hi        <= AW'(tsize_eff - 32'd1);
        res_found <= 1'b0;
        res_pos   <= '0;
      end
      S_RDHI: begin
        tl <= rdata;
      end
      S_CHK: begin
        // window check, single entry and flat range
        if ((key_r >= tl) && (key_r <= rdata)) begin
          if (lo == hi) begin
            res_found <= (tl == key_r);
            res_pos   <= (tl == key_r) ? lo : '0;
          end else if (rdata == tl) begin
            res_found <= 1'b1;
            res_pos   <= lo;
          end
        end
      end
      S_PRB: begin
        probe <= probe_w;
      end
      S_PCHK: begin
        if (rdata == key_r) begin
          res_found <= 1'b1;
          res_pos   <= probe;
        end else if (rdata < key_r) begin
          lo <= probe + 1'b1;
        end else begin
          hi <= probe - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      found    <= res_found;
      position <= POS_W'(res_pos);
    end
  end

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (position == '0))
    else $error("miss result with nonzero position");

  // every probe lies inside the current window
  a_probe_win: assert property (@(posedge clk) disable iff (rst)
    (state == S_PCHK) |-> ((probe >= lo) && (probe <= hi)))
    else $error("probe outside search window");

  // the divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW))
    else $error("divider done outside wait step");

  // a search transaction never takes a result slot before its end
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(state == S_DONE))
    else $error("result appeared without a finished search");

endmodule

// ----- hw/rtl/isrch_table.sv -----
// ----------------------------------------------------------------------------
// isrch_table
// Dual-port table memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module isrch_table
  import isrch_pkg::*;
#(
  parameter int DEPTH = ISRCH_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  data_t         wdata,
  input  logic [AW-1:0] raddr,
  output data_t         rdata
);

  data_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/isrch_div.sv -----
// ----------------------------------------------------------------------------
// isrch_div
// Probe offset unit: a multiply step, then a restoring divide with one
// quotient bit per cycle, giving floor(span * num / den).
// ----------------------------------------------------------------------------
module isrch_div
  import isrch_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [AW-1:0]     span,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              done,
  output logic [AW-1:0]     quo
);

  localparam int PW = AW + DATA_W;
  localparam int CW = $clog2(AW + 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0]        phase;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     span_r;
  logic [DATA_W-1:0] num_r;
  logic [DATA_W-1:0] den_r;
  logic [DATA_W-1:0] rem;
  logic [AW-1:0]     qsh;

  logic [PW-1:0]     prod;
  logic [DATA_W:0]   trial;
  logic              qbit;
  logic [DATA_W:0]   diff;

  // product and trial subtraction
  always_comb begin
    prod  = PW'(span_r) * PW'(num_r);
    trial = {rem, qsh[AW-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          phase <= P_DIV;
          cnt   <= CW'(AW);
        end
        P_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  // operand and remainder datapath
  always_ff @(posedge clk) begin
    if (phase == P_IDLE && start) begin
      span_r <= span;
      num_r  <= num;
      den_r  <= den;
    end
    if (phase == P_MUL) begin
      // high part is below den because the quotient fits in AW bits
      rem <= prod[PW-1:AW];
      qsh <= prod[AW-1:0];
    end else if (phase == P_DIV) begin
      rem <= qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      qsh <= AW'({qsh, qbit});
    end
  end

  assign quo = qsh;

endmodule

// ----- bench/interpolation_search_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolation_search_test
// Self-checking bench for the interpolation search block. The whole table is
// loaded first, then a short list of directed steps runs, then random phases.
// Each phase sets table_size, writes entries (a sorted or scrambled run for small
// sizes) and searches for keys that are present, near misses and out of range. A local
// mirror of the table predicts each lookup with no typed expectation; results are checked in order.
// ----------------------------------------------------------------------------
module interpolation_search_test;
  import isrch_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_CYCLES  = 500;
  localparam int SETTLE       = 8;
  localparam int TAIL         = 200;
  localparam int LIMIT        = 100_000_000;

  localparam data_t KEY_MAX = 32'sh7fffffff;
  localparam data_t KEY_MIN = 32'sh80000000;

  typedef enum logic [1:0] {STEP_CFG, STEP_WRITE, STEP_SEARCH} step_kind_t;

  typedef struct packed {
    step_kind_t       kind;
    logic [IDX_W-1:0] idx;
    data_t            arg;
    logic             typed;
    logic             hit;
    logic [POS_W-1:0] pos;
  } step_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               func;
  logic [IDX_W-1:0]   entry_index;
  data_t              entry_value;
  data_t              key;
  logic               out_valid;
  logic               out_ready;
  logic               found;
  logic [POS_W-1:0]   position;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [TSIZE_W-1:0] cfg_data;

  // mirror of the block state
  data_t              entries [ISRCH_DEPTH];
  logic [TSIZE_W-1:0] size_mirror;

  lookup_t lookup_q[$];
  lookup_t got_exp;
  step_t   plan[$];
  int      mismatches;
  int      accepted_items;
  int      steady_left;
  bit      hold_req;

  interpolation_search dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .key         (key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .position    (position),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // timeout
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // interpolation search over the mirrored table
  function automatic void interp_lookup(input data_t k, input logic [TSIZE_W-1:0] n,
                                        output logic hit, output logic [POS_W-1:0] where);
    longint lo, hi, tl, th, pr;
    hit   = 1'b0;
    where = '0;
    if (n == 0) return;
    lo = 0;
    hi = (n > ISRCH_DEPTH) ? ISRCH_DEPTH - 1 : longint'(n) - 1;
    while (lo <= hi && k >= entries[lo] && k <= entries[hi]) begin
      tl = entries[lo];
      th = entries[hi];
      // one entry left
      if (lo == hi) begin
        if (tl == k) begin
          hit   = 1'b1;
          where = POS_W'(lo);
        end
        return;
      end
      // flat span, key must equal the low end
      if (th == tl) begin
        hit   = 1'b1;
        where = POS_W'(lo);
        return;
      end
      pr = lo + ((hi - lo) * (longint'(k) - tl)) / (th - tl);
      if (pr < lo) pr = lo;
      if (pr > hi) pr = hi;
      if (entries[pr] == k) begin
        hit   = 1'b1;
        where = POS_W'(pr);
        return;
      end
      if (entries[pr] < k) lo = pr + 1;
      else hi = pr - 1;
    end
  endfunction

  function automatic step_t mk_step(step_kind_t kd, logic [IDX_W-1:0] ix, data_t a,
                                    logic ty, logic h, logic [POS_W-1:0] ps);
    step_t s;
    s.kind  = kd;
    s.idx   = ix;
    s.arg   = a;
    s.typed = ty;
    s.hit   = h;
    s.pos   = ps;
    return s;
  endfunction

  // random gap on the input side, with some stretches of none
  task automatic sender_gap();
    int n, r;
    n = 0;
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) steady_left = $urandom_range(20, 80);
      else if (r < 50) n = 0;
      else if (r < 85) n = $urandom_range(1, 3);
      else if (r < 97) n = $urandom_range(4, 15);
      else n = $urandom_range(20, 100);
    end
    if (n > 0) begin
      @(negedge clk);
      in_valid    = 1'b0;
      entry_value = data_t'($urandom);
      key         = data_t'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // offer one transaction and record what it should produce
  task automatic send_item(input logic fn, input logic [IDX_W-1:0] ix, input data_t v,
                           input data_t k, input logic typed, input logic t_hit,
                           input logic [POS_W-1:0] t_pos);
    lookup_t          e;
    logic             hit;
    logic [POS_W-1:0] where;
    @(negedge clk);
    in_valid    = 1'b1;
    func        = fn;
    entry_index = ix;
    entry_value = v;
    key         = k;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (fn == FUNC_WRITE) begin
      entries[ix] = v;
    end else begin
      if (typed) begin
        hit   = t_hit;
        where = t_pos;
      end else begin
        interp_lookup(k, size_mirror, hit, where);
      end
      e.found    = hit;
      e.position = where;
      lookup_q.push_back(e);
    end
    accepted_items++;
    sender_gap();
  endtask

  task automatic send_write(input logic [IDX_W-1:0] ix, input data_t v);
    send_item(FUNC_WRITE, ix, v, data_t'($urandom), 1'b0, 1'b0, '0);
  endtask

  task automatic send_search(input data_t k);
    send_item(FUNC_SEARCH, IDX_W'($urandom), data_t'($urandom), k, 1'b0, 1'b0, '0);
  endtask

  // stop offering and let every pending lookup come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input logic [TSIZE_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    size_mirror = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // output side: random stalls, quiet stretches and one long hold-off
  initial begin
    int quiet, stall, r;
    bit held;
    quiet     = 0;
    stall     = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        held = 1'b1;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (quiet > 0) begin
        out_ready = 1'b1;
        quiet--;
      end else begin
        out_ready = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 4) quiet = $urandom_range(40, 300);
        else if (r < 30) stall = $urandom_range(1, 3);
        else if (r < 34) stall = $urandom_range(4, 20);
        else if (r < 36) stall = $urandom_range(30, 120);
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (lookup_q.size() == 0) begin
        $error("result with nothing pending: found %0b, position %0d", found, position);
        mismatches++;
      end else begin
        got_exp = lookup_q.pop_front();
        if (got_exp.found !== found) begin
          $error("found mismatch: expected %0b, actual %0b", got_exp.found, found);
          mismatches++;
        end
        if (got_exp.position !== position) begin
          $error("position mismatch: expected %0d, actual %0d",
                 got_exp.position, position);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int               p, sz, eff, nsrch, r, first_item;
    int unsigned      step_max;
    longint           acc;
    data_t            kv;
    logic [IDX_W-1:0] ix;

    rst         = 1'b1;
    in_valid    = 1'b0;
    func        = FUNC_WRITE;
    entry_index = '0;
    entry_value = '0;
    key         = '0;
    cfg_valid   = 1'b0;
    cfg_data    = TSIZE_RESET;
    hold_req    = 1'b0;
    size_mirror = TSIZE_RESET;
    mismatches  = 0;
    steady_left = 0;

    // directed steps on a table of t[i] = 10*i
    plan.push_back(mk_step(STEP_SEARCH, 0, 0, 1, 1, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, 10230, 1, 1, 1023));
    plan.push_back(mk_step(STEP_SEARCH, 0, 5, 1, 0, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, KEY_MIN, 1, 0, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, KEY_MAX, 1, 0, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, 5120, 1, 1, 512));
    plan.push_back(mk_step(STEP_WRITE, 0, KEY_MIN, 0, 0, 0));
    plan.push_back(mk_step(STEP_WRITE, 1023, KEY_MAX, 0, 0, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, KEY_MIN, 1, 1, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, KEY_MAX, 1, 1, 1023));
    plan.push_back(mk_step(STEP_SEARCH, 0, 7770, 0, 0, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, -1, 0, 0, 0));
    // zero table size
    plan.push_back(mk_step(STEP_CFG, 0, 0, 0, 0, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, 0, 1, 0, 0));
    // single entry
    plan.push_back(mk_step(STEP_CFG, 0, 1, 0, 0, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, KEY_MIN, 1, 1, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, 10, 1, 0, 0));
    // size above depth acts as full depth
    plan.push_back(mk_step(STEP_CFG, 0, 2047, 0, 0, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, KEY_MAX, 1, 1, 1023));
    // equal end values
    plan.push_back(mk_step(STEP_CFG, 0, 3, 0, 0, 0));
    plan.push_back(mk_step(STEP_WRITE, 0, 7, 0, 0, 0));
    plan.push_back(mk_step(STEP_WRITE, 1, 7, 0, 0, 0));
    plan.push_back(mk_step(STEP_WRITE, 2, 7, 0, 0, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, 7, 1, 1, 0));
    plan.push_back(mk_step(STEP_SEARCH, 0, 8, 1, 0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // load every entry so that no search reads an unwritten one
    for (int i = 0; i < ISRCH_DEPTH; i++) send_write(IDX_W'(i), 10 * i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_CFG: begin
          wait_drained();
          write_size(plan[i].arg[TSIZE_W-1:0]);
        end
        STEP_WRITE: begin
          send_write(plan[i].idx, plan[i].arg);
        end
        default: begin
          send_item(FUNC_SEARCH, IDX_W'($urandom), data_t'($urandom), plan[i].arg,
                    plan[i].typed, plan[i].hit, plan[i].pos);
        end
      endcase
    end

    // random phases, each with its own table size
    first_item = accepted_items;
    p = 0;
    while (accepted_items - first_item < RANDOM_ITEMS) begin
      case (p)
        0: sz = 0;
        1: sz = 2047;
        2: sz = 1;
        3: sz = ISRCH_DEPTH;
        4: sz = 2;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 5) sz = $urandom_range(1025, 2047);
          else if (r < 10) sz = $urandom_range(65, 1023);
          else if (r < 15) sz = 0;
          else sz = $urandom_range(1, 48);
        end
      endcase
      eff = (sz > ISRCH_DEPTH) ? ISRCH_DEPTH : sz;
      wait_drained();
      write_size(TSIZE_W'(sz));

      if (eff > 64) begin
        // put back the linear head and tail left by small phases
        for (int i = 0; i < 64; i++) send_write(IDX_W'(i), 10 * i);
        send_write(IDX_W'(ISRCH_DEPTH - 1), 10 * (ISRCH_DEPTH - 1));
        nsrch = $urandom_range(8, 15);
      end else if (eff > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          // scrambled run
          for (int i = 0; i < eff; i++) send_write(IDX_W'(i), data_t'($urandom));
        end else begin
          // ascending run, small steps give repeats, big ones saturate
          acc = longint'(data_t'($urandom));
          if ($urandom_range(0, 7) == 0) acc = 2147483647 - $urandom_range(0, 40);
          case ($urandom_range(0, 3))
            0: step_max = 1;
            1: step_max = 16;
            2: step_max = 1 << 20;
            default: step_max = 1 << 28;
          endcase
          for (int i = 0; i < eff; i++) begin
            send_write(IDX_W'(i), data_t'(acc));
            acc += $urandom_range(0, step_max);
            if (acc > 2147483647) acc = 2147483647;
          end
        end
        nsrch = $urandom_range(10, 30);
      end else begin
        nsrch = 3;
      end

      // long output hold-off while searches keep coming
      if (p == 5) hold_req = 1'b1;

      for (int s = 0; s < nsrch; s++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // stray entry update
          if (eff > 64) begin
            ix = IDX_W'($urandom_range(0, ISRCH_DEPTH - 1));
            send_write(ix, 10 * ix + $urandom_range(0, 9));
          end else begin
            ix = IDX_W'($urandom_range(0, (eff > 0) ? eff - 1 : 63));
            send_write(ix, data_t'($urandom));
          end
        end else if (r < 12) begin
          wait_drained();
        end else begin
          r = $urandom_range(0, 9);
          if (eff > 0 && r < 6) kv = entries[$urandom_range(0, eff - 1)];
          else if (eff > 0 && r < 8)
            kv = entries[$urandom_range(0, eff - 1)] + ((r == 6) ? 1 : -1);
          else if (r == 8) kv = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
          else kv = data_t'($urandom);
          send_search(kv);
        end
      end
      p++;
    end

    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && lookup_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/isrch_pkg.sv
hw/rtl/isrch_table.sv
hw/rtl/isrch_div.sv
hw/rtl/interpolation_search.sv
bench/interpolation_search_test.sv
